FILE: rtl/cbo_pkg.sv
// ----------------------------------------------------------------------------
// cbo_pkg: shared types and constants of the cell bin overlap core.
// Holds register indexes, reset values and the structs that travel between
// the per-axis front pipeline, the slot cells and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbo_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X       = 3'd0,
		REG_ORIGIN_Y       = 3'd1,
		REG_BIN_WIDTH      = 3'd2,
		REG_BIN_HEIGHT     = 3'd3,
		REG_INV_BIN_WIDTH  = 3'd4,
		REG_INV_BIN_HEIGHT = 3'd5
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam logic signed [31:0] ORIGIN_RST  = 32'sd0;
	localparam logic        [30:0] BIN_SZ_RST  = 31'd256000;
	localparam logic        [31:0] INV_BIN_RST = 32'd16777;

	// Largest bin index that can be reported.
	localparam logic [30:0] IDX_MAX = 31'h7FFF_FFFF;

	// One axis of a cell as it leaves the front pipeline.
	typedef struct packed {
		logic        [30:0] idx;   // corrected lower bin index
		logic signed [31:0] pos;   // cell lower edge
		logic signed [32:0] fin;   // cell upper edge, pos + size
		logic signed [63:0] left;  // left edge of the bin in hand
	} axis_t;

	// Both axes of a cell, handed from cell to cell.
	typedef struct packed {
		axis_t x;
		axis_t y;
	} slot_data_t;

	// Result fields produced by one slot cell.
	typedef struct packed {
		logic [30:0] bin_x_low;
		logic [30:0] bin_y_low;
		logic [30:0] ovl_x;
		logic [30:0] ovl_y;
	} slot_result_t;

endpackage

FILE: rtl/cbo_axis_front.sv
// ----------------------------------------------------------------------------
// cbo_axis_front: lower bin index and first bin edge along one axis.
// Six-stage pipeline: difference, reciprocal estimate, edge product,
// one-step correction with clamping, exact edge product, and left edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbo_axis_front (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] pos,
	input  logic        [30:0] size,
	input  logic signed [31:0] org,
	input  logic        [30:0] bsz,
	input  logic        [31:0] inv,
	output cbo_pkg::axis_t     axis
);

	logic signed [32:0] d_s1, d_s2, d_s3;
	logic signed [31:0] pos_s1, pos_s2, pos_s3, pos_s4, pos_s5, pos_s6;
	logic signed [32:0] fin_s1, fin_s2, fin_s3, fin_s4, fin_s5, fin_s6;
	logic        [31:0] est_s2, est_s3;
	logic        [62:0] p_s3;
	logic        [30:0] idx_s4, idx_s5, idx_s6;
	logic        [61:0] q_s5;
	logic signed [63:0] left_s6;

	logic        [63:0] est_prod;
	logic        [62:0] edge_prod;
	logic        [61:0] exact_prod;
	logic signed [64:0] p_ext, pb_ext, d_ext;
	logic signed [33:0] idx_c;
	logic        [30:0] idx_clamped;

	// Reciprocal estimate: only a positive difference gives a non-zero index.
	assign est_prod = {32'b0, d_s1[31:0]} * {32'b0, inv};

	// Product of the estimate with the bin size, the estimated left edge.
	assign edge_prod = {31'b0, est_s2} * {32'b0, bsz};

	// Correct the estimate by one step against the exact edges, then clamp.
	always_comb begin
		p_ext  = $signed({2'b00, p_s3});
		pb_ext = p_ext + $signed({34'b0, bsz});
		d_ext  = $signed({{32{d_s3[32]}}, d_s3});
		if (p_ext > d_ext) begin
			idx_c = $signed({2'b00, est_s3}) - 34'sd1;
		end else if (pb_ext <= d_ext) begin
			idx_c = $signed({2'b00, est_s3}) + 34'sd1;
		end else begin
			idx_c = $signed({2'b00, est_s3});
		end
		if (idx_c[33]) begin
			idx_clamped = '0;
		end else if (idx_c[32:31] != 2'b00) begin
			idx_clamped = cbo_pkg::IDX_MAX;
		end else begin
			idx_clamped = idx_c[30:0];
		end
	end

	// Exact product of the final index with the bin size.
	assign exact_prod = {31'b0, idx_s4} * {31'b0, bsz};

	// Pipeline registers, all advancing together.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= $signed({pos[31], pos}) - $signed({org[31], org});
			pos_s1  <= pos;
			fin_s1  <= $signed({pos[31], pos}) + $signed({2'b00, size});

			est_s2  <= (!d_s1[32] && (d_s1 != '0)) ? est_prod[63:32] : '0;
			d_s2    <= d_s1;
			pos_s2  <= pos_s1;
			fin_s2  <= fin_s1;

			p_s3    <= edge_prod;
			est_s3  <= est_s2;
			d_s3    <= d_s2;
			pos_s3  <= pos_s2;
			fin_s3  <= fin_s2;

			idx_s4  <= idx_clamped;
			pos_s4  <= pos_s3;
			fin_s4  <= fin_s3;

			q_s5    <= exact_prod;
			idx_s5  <= idx_s4;
			pos_s5  <= pos_s4;
			fin_s5  <= fin_s4;

			left_s6 <= $signed({{32{org[31]}}, org}) + $signed({2'b00, q_s5});
			idx_s6  <= idx_s5;
			pos_s6  <= pos_s5;
			fin_s6  <= fin_s5;
		end
	end

	assign axis.idx  = idx_s6;
	assign axis.pos  = pos_s6;
	assign axis.fin  = fin_s6;
	assign axis.left = left_s6;

endmodule

FILE: rtl/cbo_slot_cell.sv
// ----------------------------------------------------------------------------
// cbo_slot_cell: one slot of the overlap chain.
// Holds the bin edges of one slot on both axes, gives the overlap of the
// cell with those bins and hands the next bin's left edge to its neighbour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbo_slot_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  cbo_pkg::slot_data_t   in_data,
	input  logic           [30:0] bin_width,
	input  logic           [30:0] bin_height,
	output logic                  vld,
	output cbo_pkg::slot_data_t   out_data,
	output cbo_pkg::slot_result_t res
);

	logic                vld_q;
	cbo_pkg::slot_data_t data_q;
	logic signed [63:0]  rx_q, ry_q;

	// Overlap of the span [pos, fin) with the bin [left, right), never negative.
	function automatic logic [30:0] bin_overlap(
		input logic signed [31:0] pos,
		input logic signed [32:0] fin,
		input logic signed [63:0] left,
		input logic signed [63:0] right
	);
		logic signed [63:0] pos_w, fin_w, lo, hi, ov;
		begin
			pos_w = $signed({{32{pos[31]}}, pos});
			fin_w = $signed({{31{fin[32]}}, fin});
			lo    = (pos_w > left) ? pos_w : left;
			hi    = (fin_w < right) ? fin_w : right;
			ov    = hi - lo;
			if (ov < 64'sd0) begin
				return '0;
			end
			return ov[30:0];
		end
	endfunction

	// Occupancy of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	// Slot payload and the right edges of the bins in hand.
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= in_data;
			rx_q   <= in_data.x.left + $signed({33'b0, bin_width});
			ry_q   <= in_data.y.left + $signed({33'b0, bin_height});
		end
	end

	// The next slot's bins start where these end.
	always_comb begin
		out_data        = data_q;
		out_data.x.left = rx_q;
		out_data.y.left = ry_q;
	end

	assign vld           = vld_q;
	assign res.bin_x_low = data_q.x.idx;
	assign res.bin_y_low = data_q.y.idx;
	assign res.ovl_x     = bin_overlap(data_q.x.pos, data_q.x.fin, data_q.x.left, rx_q);
	assign res.ovl_y     = bin_overlap(data_q.y.pos, data_q.y.fin, data_q.y.left, ry_q);

endmodule

FILE: rtl/cell_bin_overlap_core.sv
// ----------------------------------------------------------------------------
// cell_bin_overlap_core: lower bin indices and per-bin overlaps of a cell.
// Results of an accepted cell follow one per cycle while out_stall is low. A
// new cell enters the slot row only once the previous cell's slot is in the
// final cell, as the row feeds a single result port. Reset clears all valid
// state and loads the configuration reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cell_bin_overlap_core #(
	parameter int SLOTS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port
	input  logic                             cfg_wr_en,
	input  logic [cbo_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbo_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input cell channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [31:0]               pos_x,
	input  logic signed [31:0]               pos_y,
	input  logic        [30:0]               size_x,
	input  logic        [30:0]               size_y,
	// Result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic        [2:0]                slot,
	output logic        [30:0]               bin_x_low,
	output logic        [30:0]               bin_y_low,
	output logic        [30:0]               ovl_x,
	output logic        [30:0]               ovl_y,
	output logic                             last
);

	localparam int FRONT_STAGES = 6;

	// Configuration registers.
	logic signed [31:0] origin_x_q, origin_y_q;
	logic        [30:0] bin_width_q, bin_height_q;
	logic        [31:0] inv_bin_width_q, inv_bin_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q       <= cbo_pkg::ORIGIN_RST;
			origin_y_q       <= cbo_pkg::ORIGIN_RST;
			bin_width_q      <= cbo_pkg::BIN_SZ_RST;
			bin_height_q     <= cbo_pkg::BIN_SZ_RST;
			inv_bin_width_q  <= cbo_pkg::INV_BIN_RST;
			inv_bin_height_q <= cbo_pkg::INV_BIN_RST;
		end else if (cfg_wr_en) begin
			unique case (cbo_pkg::cfg_reg_t'(cfg_index))
				cbo_pkg::REG_ORIGIN_X:       origin_x_q       <= $signed(cfg_data);
				cbo_pkg::REG_ORIGIN_Y:       origin_y_q       <= $signed(cfg_data);
				cbo_pkg::REG_BIN_WIDTH:      bin_width_q      <= cfg_data[30:0];
				cbo_pkg::REG_BIN_HEIGHT:     bin_height_q     <= cfg_data[30:0];
				cbo_pkg::REG_INV_BIN_WIDTH:  inv_bin_width_q  <= cfg_data;
				cbo_pkg::REG_INV_BIN_HEIGHT: inv_bin_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Handshake control signals.
	logic                    out_adv;
	logic                    front_adv;
	logic                    chain_load;
	logic                    chain_busy;
	logic [FRONT_STAGES-1:0] front_vld_q;
	logic [SLOTS-1:0]        cell_vld;

	// The output register takes a new result when it is empty or being read.
	assign out_adv = !out_valid || !out_stall;

	// A cell still holding a slot other than the final one blocks a new load.
	always_comb begin
		chain_busy = 1'b0;
		for (int k = 0; k < SLOTS - 1; k++) begin
			chain_busy = chain_busy | cell_vld[k];
		end
	end

	assign chain_load = out_adv && front_vld_q[FRONT_STAGES-1] && !chain_busy;
	assign front_adv  = !front_vld_q[FRONT_STAGES-1] || chain_load;
	assign in_stall   = !front_adv;

	// Valid bits of the front pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_vld_q <= '0;
		end else if (front_adv) begin
			front_vld_q <= {front_vld_q[FRONT_STAGES-2:0], in_valid};
		end
	end

	// Per-axis index and first bin edge.
	cbo_pkg::slot_data_t front_data;

	cbo_axis_front u_front_x (
		.clk  (clk),
		.en   (front_adv),
		.pos  (pos_x),
		.size (size_x),
		.org  (origin_x_q),
		.bsz  (bin_width_q),
		.inv  (inv_bin_width_q),
		.axis (front_data.x)
	);

	cbo_axis_front u_front_y (
		.clk  (clk),
		.en   (front_adv),
		.pos  (pos_y),
		.size (size_y),
		.org  (origin_y_q),
		.bsz  (bin_height_q),
		.inv  (inv_bin_height_q),
		.axis (front_data.y)
	);

	// Row of slot cells; one cell's slot travels down the row per cycle when not stalled.
	cbo_pkg::slot_data_t   cell_out [SLOTS];
	cbo_pkg::slot_result_t cell_res [SLOTS];

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		if (k == 0) begin : g_head
			cbo_slot_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (out_adv),
				.in_vld     (chain_load),
				.in_data    (front_data),
				.bin_width  (bin_width_q),
				.bin_height (bin_height_q),
				.vld        (cell_vld[k]),
				.out_data   (cell_out[k]),
				.res        (cell_res[k])
			);
		end else begin : g_body
			cbo_slot_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (out_adv),
				.in_vld     (cell_vld[k-1]),
				.in_data    (cell_out[k-1]),
				.bin_width  (bin_width_q),
				.bin_height (bin_height_q),
				.vld        (cell_vld[k]),
				.out_data   (cell_out[k]),
				.res        (cell_res[k])
			);
		end
	end

	// Pick the result of the one occupied cell.
	cbo_pkg::slot_result_t sel_res;
	logic [2:0]            sel_slot;

	always_comb begin
		sel_res  = '0;
		sel_slot = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (cell_vld[k]) begin
				sel_res  = sel_res | cell_res[k];
				sel_slot = sel_slot | 3'(k);
			end
		end
	end

	// Output register.
	logic                  out_valid_q;
	logic                  last_q;
	logic [2:0]            slot_q;
	cbo_pkg::slot_result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= |cell_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			res_q  <= sel_res;
			slot_q <= sel_slot;
			last_q <= cell_vld[SLOTS-1];
		end
	end

	assign out_valid = out_valid_q;
	assign slot      = slot_q;
	assign bin_x_low = res_q.bin_x_low;
	assign bin_y_low = res_q.bin_y_low;
	assign ovl_x     = res_q.ovl_x;
	assign ovl_y     = res_q.ovl_y;
	assign last      = last_q;

endmodule

FILE: tb/sv/cell_bin_overlap_core_tb.sv
// ----------------------------------------------------------------------------
// cell_bin_overlap_core_tb: self-checking bench for the cell bin overlap core.
// Cells are queued by the stimulus process and driven by a bursty sender. A
// stalling receiver checks every result against a local model of the lower
// bin index search and the per-slot overlap arithmetic. Configuration changes
// between phases, once the core has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cell_bin_overlap_core_tb;

	localparam int SLOTS        = 8;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_CELLS  = 32;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;

	// Register indexes that the core does not decode.
	localparam logic [cbo_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [cbo_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_mode_t;

	typedef logic signed [79:0] wide_t;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic        [30:0] sx;
		logic        [30:0] sy;
	} cell_t;

	typedef struct {
		logic [2:0]  slot;
		logic [30:0] bx;
		logic [30:0] by;
		logic [30:0] ox;
		logic [30:0] oy;
		logic        lst;
	} bin_result_t;

	// Clock, reset and block ports.
	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [cbo_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [cbo_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	logic signed [31:0]              pos_x     = '0;
	logic signed [31:0]              pos_y     = '0;
	logic        [30:0]              size_x    = '0;
	logic        [30:0]              size_y    = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [2:0]                      slot;
	logic [30:0]                     bin_x_low;
	logic [30:0]                     bin_y_low;
	logic [30:0]                     ovl_x;
	logic [30:0]                     ovl_y;
	logic                            last;

	// Local copy of the configuration registers.
	logic signed [31:0]     grid_org_x = cbo_pkg::ORIGIN_RST;
	logic signed [31:0]     grid_org_y = cbo_pkg::ORIGIN_RST;
	logic        [30:0]     grid_bw    = cbo_pkg::BIN_SZ_RST;
	logic        [30:0]     grid_bh    = cbo_pkg::BIN_SZ_RST;
	logic        [31:0]     grid_iw    = cbo_pkg::INV_BIN_RST;
	logic        [31:0]     grid_ih    = cbo_pkg::INV_BIN_RST;

	cell_t       cell_queue[$];
	bin_result_t expected_bins[$];

	int          fail_count  = 0;
	int          cycle_count = 0;

	// Sender pacing.
	int          burst_max   = 1;
	int          gap_max     = 0;
	int          burst_left  = 0;
	int          gap_left    = 0;
	cell_t       next_cell;

	// Receiver pacing.
	stall_mode_t recv_mode   = STALL_NONE;
	int          hold_req    = 0;
	int          hold_ack    = 0;
	int          hold_left   = 0;
	int          stall_tick  = 0;
	bin_result_t want_r;

	cell_bin_overlap_core #(
		.SLOTS(SLOTS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.size_x   (size_x),
		.size_y   (size_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.slot     (slot),
		.bin_x_low(bin_x_low),
		.bin_y_low(bin_y_low),
		.ovl_x    (ovl_x),
		.ovl_y    (ovl_y),
		.last     (last)
	);

	always #4 clk = ~clk;

	// Lower bin index along one axis: reciprocal estimate, one step of
	// correction each way against the exact edges, then clamping.
	function automatic logic [30:0] lower_bin(input logic signed [31:0] pos,
			input logic signed [31:0] org, input logic [30:0] bsz,
			input logic [31:0] inv);
		wide_t p, o, b, r, d, est;
		p = pos;
		o = org;
		b = bsz;
		r = inv;
		d = p - o;
		if (d <= 0) begin
			est = 0;
		end else begin
			est = (d * r) >>> 32;
		end
		if (o + est * b > p) begin
			est = est - 1;
		end
		if (o + (est + 1) * b <= p) begin
			est = est + 1;
		end
		if (est < 0) begin
			est = 0;
		end
		if (est > wide_t'(cbo_pkg::IDX_MAX)) begin
			est = cbo_pkg::IDX_MAX;
		end
		return est[30:0];
	endfunction

	// Overlap of the cell span with bin idx + j, never below zero.
	function automatic logic [30:0] bin_overlap(input logic signed [31:0] pos,
			input logic [30:0] size, input logic signed [31:0] org,
			input logic [30:0] bsz, input logic [30:0] idx, input int j);
		wide_t p, s, o, b, ix, left, right, lo, hi, ov;
		p = pos;
		s = size;
		o = org;
		b = bsz;
		ix = idx;
		left = o + (ix + j) * b;
		right = left + b;
		lo = (p > left) ? p : left;
		hi = (p + s < right) ? p + s : right;
		ov = hi - lo;
		if (ov < 0) begin
			ov = 0;
		end
		return ov[30:0];
	endfunction

	// Expected results of one accepted cell, one per slot.
	function automatic void predict_cell_bins(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic [30:0] sx,
			input logic [30:0] sy);
		logic [30:0] bx, by;
		bin_result_t r;
		bx = lower_bin(px, grid_org_x, grid_bw, grid_iw);
		by = lower_bin(py, grid_org_y, grid_bh, grid_ih);
		for (int j = 0; j < SLOTS; j++) begin
			r.slot = j[2:0];
			r.bx   = bx;
			r.by   = by;
			r.ox   = bin_overlap(px, sx, grid_org_x, grid_bw, bx, j);
			r.oy   = bin_overlap(py, sy, grid_org_y, grid_bh, by, j);
			r.lst  = (j == SLOTS - 1);
			expected_bins.push_back(r);
		end
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
				want, got);
			fail_count++;
		end
	endtask

	// Sender: presents queued cells in bursts, predicting each transaction
	// as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_cell_bins(pos_x, pos_y, size_x, size_y);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (cell_queue.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					next_cell = cell_queue.pop_front();
					in_valid <= 1'b1;
					pos_x    <= next_cell.px;
					pos_y    <= next_cell.py;
					size_x   <= next_cell.sx;
					size_y   <= next_cell.sy;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, burst_max);
					end
					burst_left--;
					if (burst_left == 0 && gap_max > 0) begin
						gap_left = $urandom_range(0, gap_max);
					end
				end
			end
		end
	end

	// Receiver: checks each accepted result and decides the next stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bins.size() == 0) begin
					$display("%0t: result with no cell pending, expected none, actual slot %0d",
						$time, slot);
					fail_count++;
				end else begin
					want_r = expected_bins.pop_front();
					check_field("slot", want_r.slot, slot);
					check_field("bin_x_low", want_r.bx, bin_x_low);
					check_field("bin_y_low", want_r.by, bin_y_low);
					check_field("ovl_x", want_r.ox, ovl_x);
					check_field("ovl_y", want_r.oy, ovl_y);
					check_field("last", want_r.lst, last);
				end
			end
			stall_tick++;
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (recv_mode)
					STALL_RANDOM: begin
						out_stall <= ($urandom_range(0, 2) == 0);
					end
					STALL_PATTERN: begin
						out_stall <= ((stall_tick % 11) < 4);
					end
					default: begin
						out_stall <= 1'b0;
					end
				endcase
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input logic [cbo_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			cbo_pkg::REG_ORIGIN_X:       grid_org_x = data;
			cbo_pkg::REG_ORIGIN_Y:       grid_org_y = data;
			cbo_pkg::REG_BIN_WIDTH:      grid_bw    = data[30:0];
			cbo_pkg::REG_BIN_HEIGHT:     grid_bh    = data[30:0];
			cbo_pkg::REG_INV_BIN_WIDTH:  grid_iw    = data;
			cbo_pkg::REG_INV_BIN_HEIGHT: grid_ih    = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic write_all(input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] bw, input logic [31:0] bh, input logic [31:0] iw,
			input logic [31:0] ih);
		write_reg(cbo_pkg::REG_ORIGIN_X, ox);
		write_reg(cbo_pkg::REG_ORIGIN_Y, oy);
		write_reg(cbo_pkg::REG_BIN_WIDTH, bw);
		write_reg(cbo_pkg::REG_BIN_HEIGHT, bh);
		write_reg(cbo_pkg::REG_INV_BIN_WIDTH, iw);
		write_reg(cbo_pkg::REG_INV_BIN_HEIGHT, ih);
	endtask

	task automatic add_cell(input logic [31:0] px, input logic [31:0] py,
			input logic [30:0] sx, input logic [30:0] sy);
		cell_t c;
		c.px = px;
		c.py = py;
		c.sx = sx;
		c.sy = sy;
		cell_queue.push_back(c);
	endtask

	// Waits until every queued cell is accepted and every result is back,
	// then lets the pipeline settle.
	task automatic wait_idle();
		while (cell_queue.size() != 0 || in_valid || expected_bins.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Random grid for one axis: mostly moderate bins with a near-exact
	// reciprocal, sometimes a poor one, a zero bin or a huge bin.
	task automatic rand_axis(output logic [31:0] org, output logic [31:0] bsz,
			output logic [31:0] inv);
		longint b, q, o;
		case ($urandom_range(0, 9))
			0:       b = 0;
			1:       b = 64'h7FFF_FFFF - $urandom_range(0, 1000);
			2, 3:    b = $urandom_range(1, 300);
			default: b = $urandom_range(1 << 10, 1 << 22);
		endcase
		if (b == 0) begin
			q = longint'($urandom);
		end else begin
			q = (longint'(1) << 32) / b;
		end
		if (q > 64'hFFFF_FFFF) begin
			q = 64'hFFFF_FFFF;
		end
		case ($urandom_range(0, 7))
			0:       q = longint'($urandom);
			1:       q = q + q / 4;
			2:       q = q / 2;
			3:       q = 0;
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0) begin
			o = longint'($urandom);
		end else begin
			o = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
		end
		org = o[31:0];
		bsz = b[31:0];
		inv = q[31:0];
	endtask

	// Random cell span on one axis: mostly placed on the grid with sizes of
	// a few bins, the rest arbitrary bit patterns.
	task automatic rand_span(input logic signed [31:0] org, input logic [30:0] bsz,
			output logic [31:0] pos, output logic [30:0] size);
		longint o, b, p, s, k;
		o = org;
		b = bsz;
		if ($urandom_range(0, 9) == 0) begin
			p = longint'($urandom);
			s = longint'($urandom);
		end else begin
			k = longint'($urandom_range(0, 22)) - 2;
			p = o + k * b + ((b == 0) ? 0 : longint'($urandom) % b);
			case ($urandom_range(0, 4))
				0:       s = 0;
				1:       s = longint'($urandom) % (b + 1);
				2, 3:    s = longint'($urandom_range(0, 9)) * b
						+ longint'($urandom) % (b + 1);
				default: s = longint'($urandom);
			endcase
		end
		pos = p[31:0];
		size = s[30:0];
	endtask

	// Stimulus: directed cells first, then random phases.
	initial begin
		logic [31:0] ox, oy, bw, bh, iw, ih, px, py;
		logic [30:0] sx, sy;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset grid: origin, bin edges, negative and extreme positions.
		burst_max = 4;
		gap_max = 3;
		recv_mode = STALL_RANDOM;
		add_cell(32'h0, 32'h0, 31'h0, 31'h0);
		add_cell(32'd768000, 32'd256000, 31'd256000, 31'd512000);
		add_cell(32'hFFFF_FFFF, 32'hFFFF_0000, 31'd300000, 31'd1);
		add_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_cell(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_cell(32'd255999, 32'd256001, 31'd1, 31'd255999);
		add_cell(32'd1000000, 32'd5000000, 31'd2048005, 31'd700000);
		add_cell(32'h0012_3456, 32'hFFED_CBA9, 31'h0005_5555, 31'h2AAA_AAAA);
		wait_idle();

		// Extreme origins and bin sizes; the index saturates.
		write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'd2);
		@(negedge clk);
		recv_mode = STALL_PATTERN;
		add_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd5, 31'h7FFF_FFFF);
		add_cell(32'h0000_0000, 32'h8000_0000, 31'd3, 31'd12345);
		add_cell(32'h8000_0000, 32'h7FFF_FFFE, 31'h0, 31'd2);
		wait_idle();

		// Zero reciprocal: the estimate stays low and moves by one step only.
		write_all(32'h0, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
		@(negedge clk);
		add_cell(32'h0005_0000, 32'h0003_8000, 31'h0002_0000, 31'h0000_8000);
		add_cell(32'h0000_FFFF, 32'hFFFE_0000, 31'h0009_0000, 31'h0001_0000);
		wait_idle();

		// Zero bin size, writes to undecoded indexes and dropped upper bits.
		write_reg(cbo_pkg::REG_BIN_WIDTH, 32'h0);
		write_reg(cbo_pkg::REG_BIN_HEIGHT, 32'h0);
		write_reg(REG_SPARE_6, 32'h1234_5678);
		write_reg(REG_SPARE_7, 32'hFFFF_FFFF);
		@(negedge clk);
		add_cell(32'h0004_0000, 32'hFFFF_0000, 31'h7FFF_FFFF, 31'h0001_0000);
		add_cell(32'h0, 32'h0, 31'h0, 31'h0);
		wait_idle();
		write_reg(cbo_pkg::REG_BIN_WIDTH, 32'h8000_4000);
		write_reg(cbo_pkg::REG_BIN_HEIGHT, 32'hFFFF_C000);
		write_reg(cbo_pkg::REG_INV_BIN_WIDTH, 32'h0004_0000);
		write_reg(cbo_pkg::REG_INV_BIN_HEIGHT, 32'h0004_0000);
		@(negedge clk);
		add_cell(32'h0001_2345, 32'hFFFF_8000, 31'h0001_0000, 31'h0003_0000);

		// Random phases, each with a grid of its own.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			rand_axis(ox, bw, iw);
			rand_axis(oy, bh, ih);
			write_all(ox, oy, bw, bh, iw, ih);
			@(negedge clk);
			burst_max = $urandom_range(1, 12);
			gap_max = $urandom_range(0, 10);
			recv_mode = stall_mode_t'($urandom_range(0, 2));
			if (ph == 0) begin
				// A stretch with no idling on either side.
				gap_max = 0;
				recv_mode = STALL_NONE;
			end else if (ph == 2) begin
				// The receiver holds off while the sender keeps offering.
				gap_max = 0;
				hold_req++;
			end
			for (int i = 0; i < PHASE_CELLS; i++) begin
				rand_span(grid_org_x, grid_bw, px, sx);
				rand_span(grid_org_y, grid_bh, py, sy);
				add_cell(px, py, sx, sy);
			end
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
